/* sv/htiu_pkg.sv */
// Package with the shared types, codes and constants of the timer and interrupt unit.
`default_nettype none

package htiu_pkg;

  localparam int unsigned SourceCount = 5;
  localparam int unsigned TimerSource = 2;
  localparam logic [8:0]  DivLimit    = 9'd255;
  localparam logic [6:0]  VectorBase  = 7'h40;
  localparam logic [7:0]  CounterMax  = 8'd255;

  // Configuration register indexes.
  localparam logic [7:0] CfgTimerReload  = 8'd0;
  localparam logic [7:0] CfgTimerEnable  = 8'd1;
  localparam logic [7:0] CfgRateSelect   = 8'd2;
  localparam logic [7:0] CfgIrqEnable    = 8'd3;

  typedef enum logic [1:0] {
    OpTick   = 2'd0,
    OpRaise  = 2'd1,
    OpSetIme = 2'd2,
    OpClrIme = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] cycles;
    logic [4:0] request_bits;
  } in_item_t;

  typedef struct packed {
    logic       irq_taken;
    logic [6:0] vector;
    logic [7:0] div_value;
    logic [7:0] counter_value;
    logic [4:0] pending_flags;
  } out_item_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] value;
  } cfg_write_t;

  // Countdown reload value for each rate select code.
  function automatic logic signed [11:0] rate_reload(input logic [1:0] sel);
    logic signed [11:0] r;
    unique case (sel)
      2'd0: r = 12'sd1024;
      2'd1: r = 12'sd16;
      2'd2: r = 12'sd64;
      default: r = 12'sd256;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/htiu_chan_if.sv */
// Valid/ready channel interface used for the request, result and configuration channels.
`default_nettype none

interface htiu_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/handheld_timer_interrupt_unit.sv */
// Top level of the timer and interrupt unit: timers, request flags and dispatch.
`default_nettype none

// Each request is accepted, the divider, countdown, counter and
// interrupt flags are updated from it in the same edge, and its result is loaded into
// a single output register. A new request is accepted in every cycle while the result
// register is empty or its result is being taken, so the sustained rate is one request
// per cycle, set by the single output register. Configuration writes are always
// accepted and take effect at the edge of the write.
module handheld_timer_interrupt_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  htiu_chan_if.sink   in_i,
  htiu_chan_if.source out_o,
  htiu_chan_if.sink   cfg_i
);

  logic [7:0]         timer_reload_q;
  logic               timer_enable_q;
  logic [1:0]         rate_select_q;
  logic [4:0]         irq_enable_q;

  logic [8:0]         div_accum_q, div_accum_d;
  logic [7:0]         div_reg_q, div_reg_d;
  logic [7:0]         counter_q, counter_d;
  logic signed [11:0] countdown_q, countdown_d;
  logic [4:0]         pending_q, pending_d;
  logic               ime_q, ime_d;

  logic               out_valid_q;
  htiu_pkg::out_item_t out_q, out_d;

  htiu_pkg::in_item_t in_item;
  htiu_pkg::cfg_write_t cfg_item;
  logic               in_accept;

  assign in_item   = in_i.data;
  assign cfg_item  = cfg_i.data;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign in_accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_reload_q <= '0;
      timer_enable_q <= 1'b0;
      rate_select_q  <= '0;
      irq_enable_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_item.index)
        htiu_pkg::CfgTimerReload: timer_reload_q <= cfg_item.value;
        htiu_pkg::CfgTimerEnable: timer_enable_q <= cfg_item.value[0];
        htiu_pkg::CfgRateSelect:  rate_select_q  <= cfg_item.value[1:0];
        htiu_pkg::CfgIrqEnable:   irq_enable_q   <= cfg_item.value[4:0];
        default: ;
      endcase
    end
  end

  logic [8:0]         accum_sum;
  logic signed [11:0] countdown_sub;
  logic [4:0]         pend_timer;
  logic [4:0]         ready_bits;
  logic               found;
  logic [2:0]         src_idx;

  always_comb begin
    div_accum_d = div_accum_q;
    div_reg_d   = div_reg_q;
    counter_d   = counter_q;
    countdown_d = countdown_q;
    pending_d   = pending_q;
    ime_d       = ime_q;
    pend_timer  = pending_q;
    found       = 1'b0;
    src_idx     = '0;

    accum_sum     = div_accum_q + {1'b0, in_item.cycles};
    countdown_sub = countdown_q - $signed({4'b0000, in_item.cycles});

    out_d.irq_taken = 1'b0;
    out_d.vector    = '0;

    unique case (in_item.op)
      htiu_pkg::OpTick: begin
        if (accum_sum >= htiu_pkg::DivLimit) begin
          div_accum_d = '0;
          div_reg_d   = div_reg_q + 8'd1;
        end else begin
          div_accum_d = accum_sum;
        end
        if (timer_enable_q) begin
          countdown_d = countdown_sub;
          if (countdown_sub <= 12'sd0) begin
            countdown_d = htiu_pkg::rate_reload(rate_select_q);
            if (counter_q == htiu_pkg::CounterMax) begin
              counter_d = timer_reload_q;
              pend_timer[htiu_pkg::TimerSource] = 1'b1;
            end else begin
              counter_d = counter_q + 8'd1;
            end
          end
        end
        pending_d = pend_timer;
        if (ime_q) begin
          ready_bits = pend_timer & irq_enable_q;
          // The lowest enabled pending source wins.
          for (int i = htiu_pkg::SourceCount - 1; i >= 0; i--) begin
            if (ready_bits[i]) begin
              found   = 1'b1;
              src_idx = 3'(i);
            end
          end
        end else begin
          ready_bits = '0;
        end
        if (found) begin
          pending_d[src_idx] = 1'b0;
          ime_d              = 1'b0;
          out_d.irq_taken    = 1'b1;
          out_d.vector       = htiu_pkg::VectorBase + {1'b0, src_idx, 3'b000};
        end
      end
      htiu_pkg::OpRaise: begin
        ready_bits = '0;
        pending_d  = pending_q | in_item.request_bits;
      end
      htiu_pkg::OpSetIme: begin
        ready_bits = '0;
        ime_d      = 1'b1;
      end
      default: begin
        ready_bits = '0;
        ime_d      = 1'b0;
      end
    endcase

    out_d.div_value     = div_reg_d;
    out_d.counter_value = counter_d;
    out_d.pending_flags = pending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_accum_q <= '0;
      div_reg_q   <= '0;
      counter_q   <= '0;
      countdown_q <= '0;
      pending_q   <= '0;
      ime_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        div_accum_q <= div_accum_d;
        div_reg_q   <= div_reg_d;
        counter_q   <= counter_d;
        countdown_q <= countdown_d;
        pending_q   <= pending_d;
        ime_q       <= ime_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

/* sv/htiu_checker.sv */
// Port-level checks of the timer and interrupt unit, bound to its top level.
`default_nettype none

module htiu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic [1:0] in_op_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       out_irq_taken_i,
  input wire logic [6:0] out_vector_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // An accepted request always produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted request gave no result");

  // The block never stalls a request while its result register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request stalled with empty result register");

  // Only a tick can dispatch an interrupt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i != htiu_pkg::OpTick |=> !out_irq_taken_i)
    else $error("interrupt dispatched on a non-tick request");

  // A vector is shown exactly when an interrupt is taken, and it is a multiple of eight no higher than 96.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_irq_taken_i == (out_vector_i != 7'd0)) &&
                    (out_vector_i[2:0] == 3'd0) && (out_vector_i <= 7'd96))
    else $error("vector inconsistent with irq_taken");

endmodule

bind handheld_timer_interrupt_unit htiu_checker u_htiu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_op_i         (in_i.data.op),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_irq_taken_i (out_o.data.irq_taken),
  .out_vector_i    (out_o.data.vector)
);

`default_nettype wire
